// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_NOW(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

// File: rtl/cmag_pkg.sv
// ---------------------------------------------------------------------------
// cmag_pkg
// widths, register map and cell record for the magnitude-to-luminance block
// ---------------------------------------------------------------------------
`default_nettype none

package cmag_pkg;

	localparam int AMP_WIDTH  = 24;
	localparam int ENERGY_W   = 2 * AMP_WIDTH;      // re^2 + im^2 stays below 2^(2w-1)+1
	localparam int FRAC_SHIFT = 16;                 // 8 fractional root bits
	localparam int RAD_W      = ENERGY_W + FRAC_SHIFT;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int LUM_W      = 8;
	localparam int LOG2_W     = 3;
	localparam int SHIFT_W    = LOG2_W + 1;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 3;

	localparam logic [LOG2_W-1:0] LOG2_SIDE_RESET = LOG2_W'(6);

	// register word index (paddr[2])
	localparam logic REG_LOG2_SIDE = 1'b0;

	localparam logic [LUM_W-1:0] LUM_MAX = {LUM_W{1'b1}};

	typedef struct packed {
		logic              valid;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} cmag_cell_t;

endpackage

`default_nettype wire

// File: rtl/cmag_energy.sv
// ---------------------------------------------------------------------------
// cmag_energy
// three-stage front end: absolute values, squares, sum of squares
// ---------------------------------------------------------------------------
`default_nettype none

module cmag_energy (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                adv,
	input  wire                                valid,
	input  wire signed [cmag_pkg::AMP_WIDTH-1:0] amp_real,
	input  wire signed [cmag_pkg::AMP_WIDTH-1:0] amp_imag,
	output cmag_pkg::cmag_cell_t               head
);
	import cmag_pkg::*;

	logic                  v_s1, v_s2;
	logic [AMP_WIDTH-1:0]  abs_re_s1, abs_im_s1;
	logic [ENERGY_W-1:0]   sq_re_s2, sq_im_s2;
	cmag_cell_t            data_s3;
	logic [AMP_WIDTH-1:0]  abs_re, abs_im;
	logic [ENERGY_W-1:0]   energy;

	// most negative value maps to 2^(w-1), which still fits unsigned
	assign abs_re = amp_real[AMP_WIDTH-1] ? (~amp_real + 1'b1) : amp_real;
	assign abs_im = amp_imag[AMP_WIDTH-1] ? (~amp_imag + 1'b1) : amp_imag;
	assign energy = sq_re_s2 + sq_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			data_s3 <= '0;
		end else if (adv) begin
			v_s1          <= valid;
			v_s2          <= v_s1;
			data_s3.valid <= v_s2;
			data_s3.rad   <= {energy, {FRAC_SHIFT{1'b0}}};
			data_s3.rem   <= '0;
			data_s3.root  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			abs_re_s1    <= abs_re;
			abs_im_s1    <= abs_im;
			sq_re_s2     <= abs_re_s1 * abs_re_s1;
			sq_im_s2     <= abs_im_s1 * abs_im_s1;
		end
	end

	assign head = data_s3;

endmodule

`default_nettype wire

// File: rtl/cmag_cell.sv
// ---------------------------------------------------------------------------
// cmag_cell
// one restoring square-root step: retires two radicand bits, yields one root bit
// ---------------------------------------------------------------------------
`default_nettype none

module cmag_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  cmag_pkg::cmag_cell_t prev,
	output cmag_pkg::cmag_cell_t next
);
	import cmag_pkg::*;

	logic [REM_W-1:0] cur, trial;
	logic             take;
	cmag_cell_t       data_q;

	assign cur   = {prev.rem[REM_W-3:0], prev.rad[RAD_W-1 -: 2]};
	assign trial = {1'b0, prev.root, 2'b01};
	assign take  = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (adv) begin
			data_q.valid <= prev.valid;
			data_q.rad   <= {prev.rad[RAD_W-3:0], 2'b00};
			data_q.rem   <= take ? (cur - trial) : cur;
			data_q.root  <= {prev.root[ROOT_W-2:0], take};
		end
	end

	assign next = data_q;

endmodule

`default_nettype wire

// File: rtl/complex_magnitude_to_luminance.sv
// ---------------------------------------------------------------------------
// complex_magnitude_to_luminance
// complex amplitude to 8-bit pixel: min(255, isqrt((re^2+im^2)<<16) >> 2k)
// ---------------------------------------------------------------------------
// pipeline from input transaction to luminance valid:
//   (3 front-end stages, 32 root cells, 1 output register)
// throughput: one transaction per cycle while the output is not stalled; each root cell finishes one bit per cycle
// the whole chain holds while a result waits on a stalled output
// reset: asynchronous, clears all valid bits and sets log2_side to 6
`default_nettype none

`include "assert_macros.svh"

module complex_magnitude_to_luminance (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input channel
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [cmag_pkg::AMP_WIDTH-1:0] amp_real,
	input  wire signed [cmag_pkg::AMP_WIDTH-1:0] amp_imag,
	// output channel
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [cmag_pkg::LUM_W-1:0]           luminance,
	// configuration port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [cmag_pkg::PADDR_W-1:0]         paddr,
	input  wire  [cmag_pkg::DATA_W-1:0]          pwdata,
	output logic [cmag_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);
	import cmag_pkg::*;

	logic                 adv;
	logic [LOG2_W-1:0]    log2_side_q;
	cmag_cell_t           chain [0:ROOT_W];
	logic                 out_valid_q;
	logic [LUM_W-1:0]     luminance_q;
	logic [SHIFT_W-1:0]   shift;
	logic [ROOT_W-1:0]    scaled;
	logic [LUM_W-1:0]     pix;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_side_q <= LOG2_SIDE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LOG2_SIDE) begin
			log2_side_q <= pwdata[LOG2_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_LOG2_SIDE: prdata = {{(DATA_W-LOG2_W){1'b0}}, log2_side_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// the whole chain moves unless a finished result is held by the sink
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// ---------------- front end: |re|, |im|, squares, sum ----------------
	cmag_energy u_energy (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid    (in_valid),
		.amp_real (amp_real),
		.amp_imag (amp_imag),
		.head     (chain[0])
	);

	// ---------------- square-root chain, msb of root first ----------------
	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		cmag_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	// ---------------- normalize by element count and saturate ----------------
	// divide by side^2 means a right shift of 2*log2_side bits
	assign shift  = {log2_side_q, 1'b0};
	assign scaled = chain[ROOT_W].root >> shift;
	assign pix    = (|scaled[ROOT_W-1:LUM_W]) ? LUM_MAX : scaled[LUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[ROOT_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			luminance_q <= pix;
		end
	end

	assign out_valid = out_valid_q;
	assign luminance = luminance_q;

	// ---------------- checks ----------------
	// a finished root reaches the output register when the chain moves
	`ASSERT_NEXT(a_tail_to_out, clk, arst_n, chain[ROOT_W].valid && adv, out_valid)
	// a held result freezes the tail of the chain
	`ASSERT_NEXT(a_hold_tail, clk, arst_n, out_valid && out_stall, $stable(chain[ROOT_W].valid))
	// a taken result with nothing behind it leaves the output empty
	`ASSERT_NEXT(a_drain, clk, arst_n, out_valid && !out_stall && !chain[ROOT_W].valid,
		!out_valid)
	// restoring remainder never exceeds twice the partial root
	`ASSERT_NOW(a_rem_bound, clk, arst_n, chain[ROOT_W].valid,
		chain[ROOT_W].rem <= {2'b00, chain[ROOT_W].root, 1'b0})

endmodule

`default_nettype wire
